// ===== src/lpht_pkg.sv =====
// Shared types and codes for the linear-probing hash table.
// Holds the request and response transfer structs and the operation, status and slot flag codes.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int FLAG_W   = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Response status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

	// Slot flag codes kept in the slot memory.
	localparam logic [FLAG_W-1:0] FLAG_FREE     = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_OCCUPIED = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_DELETED  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] lookup_key;
		logic [VAL_W-1:0] entry_value;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    found_value;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_item_t;

endpackage

// ===== src/lpht_hash.sv =====
// Start slot unit: reduces the low 32 key bits modulo the slot count.
// A power-of-two slot count is a plain mask; any other count is reduced four bits per cycle.
// No dependencies.
`timescale 1ns / 1ps

module lpht_hash #(
	parameter int SLOT_COUNT = 1024,
	parameter int SW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   key_low,
	output logic          done,
	output logic [SW-1:0] slot
);

	localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
	localparam int DIGIT = 4;
	localparam int STEPS = 32 / DIGIT;
	localparam int CNT_W = $clog2(STEPS);

	generate
		if (IS_POW2) begin : g_mask
			// The remainder is just the low key bits.
			assign done = start;
			assign slot = key_low[SW-1:0];
		end else begin : g_serial
			logic [31:0]      sh_q;
			logic [SW-1:0]    rem_q;
			logic [CNT_W-1:0] cnt_q;
			logic             busy_q;
			logic             done_q;
			logic [SW-1:0]    rem_next;

			// Four restoring steps of long division by the slot count.
			always_comb begin
				logic [SW:0] t;
				rem_next = rem_q;
				for (int i = 0; i < DIGIT; i++) begin
					t = {rem_next, sh_q[31 - i]};
					if (t >= (SW + 1)'(SLOT_COUNT)) begin
						t = t - (SW + 1)'(SLOT_COUNT);
					end
					rem_next = t[SW-1:0];
				end
			end

			// The sequencer walks the key one digit per cycle.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= !start && busy_q && (cnt_q == CNT_W'(STEPS - 1));
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(STEPS - 1)) begin
							busy_q <= 1'b0;
						end
					end
				end
			end

			// The shift register and remainder carry no reset.
			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= key_low;
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= {sh_q[31-DIGIT:0], {DIGIT{1'b0}}};
					rem_q <= rem_next;
				end
			end

			assign done = done_q;
			assign slot = rem_q;
		end
	endgenerate

endmodule

// ===== src/linear_probe_hash_table_core.sv =====
// Open-addressing key/value table with linear probing.
// Request channel (req_valid, req_stall, req) carries an operation, a 64-bit key and a value.
// Response channel (rsp_valid, rsp_stall, rsp) returns one status, value and entry count per
// request. Both use valid/stall: a transfer completes on a clock edge with valid high and
// stall low.
// Requests are processed one at a time. A request probes slots one after another from its
// start slot; the slot memory is read once per cycle. With a SLOT_COUNT that is not a power
// of two the start slot is first reduced serially. An insert into a full table and an
// unused operation code answer without probing.
// After reset the block clears every slot flag, one slot per cycle, and holds req_stall
// high meanwhile.
// The response sits in an output register; a new request is taken while it waits. If the
// receiver stalls, the next finished request waits in its final state until the register
// frees up.
// Depends on lpht_pkg and lpht_hash.
`timescale 1ns / 1ps

module linear_probe_hash_table_core
	import lpht_pkg::*;
#(
	parameter int SLOT_COUNT = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int WW = FLAG_W + KEY_W + VAL_W;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_HASH   = 3'd2;
	localparam logic [2:0] ST_PROBE  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	// Control state.
	logic [2:0]          state_q;
	logic [SW-1:0]       clr_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       n_q;
	logic                eval_s1;
	logic [CW-1:0]       occ_q;
	logic                wr_q;
	logic                rsp_valid_q;

	// Payload state.
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [SW-1:0]       slot_s1;
	logic [WW-1:0]       rdata_s1;
	logic [SW-1:0]       wr_slot_q;
	logic [FLAG_W-1:0]   wr_flag_q;
	logic [VAL_W-1:0]    wr_val_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    found_q;
	rsp_item_t           rsp_q;

	logic [WW-1:0]       mem [SLOT_COUNT];

	logic                accept;
	logic                hash_start;
	logic                hash_done;
	logic [SW-1:0]       hash_slot;
	logic [FLAG_W-1:0]   rflag;
	logic [KEY_W-1:0]    rkey;
	logic [VAL_W-1:0]    rval;
	logic                hit;
	logic                miss;
	logic                full_sweep;
	logic                probe_stop;
	logic [SW-1:0]       slot_next;
	logic                rsp_load;
	logic [CW-1:0]       occ_next;
	logic                mem_we;
	logic [SW-1:0]       mem_waddr;
	logic [WW-1:0]       mem_wdata;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Start a slot reduction for every operation that probes.
	assign hash_start = accept && (req.operation == OP_SEARCH || req.operation == OP_DELETE ||
		(req.operation == OP_INSERT && occ_q != CW'(SLOT_COUNT)));

	lpht_hash #(
		.SLOT_COUNT(SLOT_COUNT),
		.SW        (SW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key_low(req.lookup_key[31:0]),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	// Decode the slot word read in the previous cycle.
	assign rflag = rdata_s1[WW-1 -: FLAG_W];
	assign rkey  = rdata_s1[KEY_W + VAL_W - 1 -: KEY_W];
	assign rval  = rdata_s1[VAL_W-1:0];

	assign slot_next  = (slot_q == SW'(SLOT_COUNT - 1)) ? '0 : slot_q + 1'b1;
	assign full_sweep = (n_q == SW'(SLOT_COUNT - 1));

	// Probe decision: inserts stop at the first slot that is not occupied or after a full sweep;
	// lookups stop at a matching key, a free slot or after a full sweep.
	always_comb begin
		hit  = 1'b0;
		miss = 1'b0;
		if (eval_s1) begin
			if (op_q == OP_INSERT) begin
				if (rflag != FLAG_OCCUPIED) begin
					hit = 1'b1;
				end else if (full_sweep) begin
					miss = 1'b1;
				end
			end else begin
				if (rflag == FLAG_OCCUPIED && rkey == key_q) begin
					hit = 1'b1;
				end else if (rflag == FLAG_FREE || full_sweep) begin
					miss = 1'b1;
				end
			end
		end
	end
	assign probe_stop = hit || miss;

	// Count update on completion of a successful insert or delete.
	always_comb begin
		occ_next = occ_q;
		if (wr_q && op_q == OP_INSERT) begin
			occ_next = occ_q + 1'b1;
		end else if (wr_q && op_q == OP_DELETE) begin
			occ_next = occ_q - 1'b1;
		end
	end

	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);

	// Slot memory write port: clearing sweep after reset, or the final update of a request.
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_FINISH && wr_q);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wr_slot_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {wr_flag_q, key_q, wr_val_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[slot_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			eval_s1     <= 1'b0;
			occ_q       <= '0;
			wr_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The response register fills when a request finishes and empties on a transfer.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			// A slot word read while probing is evaluated in the next cycle.
			eval_s1 <= (state_q == ST_PROBE) && !probe_stop;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						wr_q <= 1'b0;
						n_q  <= '0;
						if (hash_start) begin
							slot_q  <= hash_slot;
							state_q <= hash_done ? ST_PROBE : ST_HASH;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						slot_q  <= hash_slot;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (probe_stop) begin
						wr_q    <= hit && (op_q == OP_INSERT || op_q == OP_DELETE);
						state_q <= ST_FINISH;
					end else begin
						slot_q <= slot_next;
						if (eval_s1) begin
							n_q <= n_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (rsp_load) begin
						occ_q   <= occ_next;
						wr_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, probe results and the response register.
	always_ff @(posedge clk) begin
		slot_s1 <= slot_q;
		if (accept) begin
			op_q     <= req.operation;
			key_q    <= req.lookup_key;
			val_q    <= req.entry_value;
			found_q  <= '0;
			status_q <= (req.operation == OP_INSERT) ? STATUS_FULL : STATUS_MISSING;
		end
		if (state_q == ST_PROBE && probe_stop) begin
			wr_slot_q <= slot_s1;
			if (op_q == OP_INSERT) begin
				wr_flag_q <= FLAG_OCCUPIED;
				wr_val_q  <= val_q;
				status_q  <= hit ? STATUS_OK : STATUS_FULL;
			end else begin
				wr_flag_q <= FLAG_DELETED;
				wr_val_q  <= rval;
				status_q  <= hit ? STATUS_OK : STATUS_MISSING;
				found_q   <= hit ? rval : '0;
			end
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.found_value <= found_q;
			rsp_q.entry_count <= COUNT_W'(occ_next);
		end
	end

endmodule
